/* rtl/core/lirs_pkg.sv */
// lirs_pkg.sv: shared types and constants of the linear-interpolation resampler
package lirs_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int PHASE_W      = 36;
  localparam int FRAC_W       = 32;
  localparam int CHCNT_W      = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int MAX_UPSAMPLE = 8;
  localparam int CNT_W        = (MAX_UPSAMPLE > 1) ? $clog2(MAX_UPSAMPLE) : 1;
  localparam int QDEPTH       = 2;
  localparam int QPTR_W       = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W       = $clog2(QDEPTH + 1);

  localparam logic [PHASE_W-1:0] PHASE_ONE  = PHASE_W'(64'd1 << FRAC_W);
  localparam logic [PHASE_W-1:0] STEP_RESET = PHASE_ONE;
  localparam logic [CHCNT_W-1:0] CHCNT_RESET = CHCNT_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP    = 2'd0,
    CFG_CHANNEL_COUNT = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_ch0;
    logic signed [SAMPLE_W-1:0] sample_ch1;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_ch0;
    logic signed [SAMPLE_W-1:0] out_ch1;
    logic                       last_of_run;
  } out_t;

  // queued frame, tagged by the front end
  typedef struct packed {
    logic prime;   // first frame after reset, only stored
    in_t  frame;
  } item_t;

endpackage

/* rtl/core/linear_interp_audio_resampler.sv */
// linear_interp_audio_resampler.sv: top level of the linear-interpolation resampler
//
// in channel: one PCM frame (two 16-bit samples) per word, in_valid/in_stall.
// out channel: interpolated frames, out_valid/out_stall; last_of_run marks the
//   final word produced by one input frame.
// cfg channel: cfg_valid/cfg_ready (always ready), index 0 = phase step (4.32),
//   index 1 = channel count; write only while the block is idle.
// A two-word queue decouples input acceptance from the interpolation engine.
// Each input frame is popped in the idle state and then issues its output words
// (up to 8) through the single shared multiplier pair; the next frame is popped
// only after that run ends. The first output word passes the queue, the start,
// the multiplier register and the output register.
// The first frame after reset is only stored. Reset clears the phase, the
// previous frame, the queue and restores step one and two channels.
// When the receiver stalls, the output and multiplier registers hold, the
// engine pauses, and in_stall rises once the queue is full.
module linear_interp_audio_resampler (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  lirs_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output lirs_pkg::out_t                  out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lirs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lirs_pkg::PHASE_W-1:0]    cfg_data
);
  import lirs_pkg::*;

  logic [PHASE_W-1:0] phase_step;
  logic [CHCNT_W-1:0] channel_count;
  logic               q_valid;
  logic               q_pop;
  item_t              q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step    <= STEP_RESET;
      channel_count <= CHCNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_PHASE_STEP) begin
        phase_step <= cfg_data;
      end else if (cfg_index == CFG_CHANNEL_COUNT) begin
        channel_count <= cfg_data[CHCNT_W-1:0];
      end
    end
  end

  lirs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  lirs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .phase_step    (phase_step),
    .channel_count (channel_count),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_item        (q_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

endmodule

/* rtl/core/lirs_front.sv */
// lirs_front.sv: input acceptance, first-frame tagging and frame queue
module lirs_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  lirs_pkg::in_t  in_data,
  output logic           q_valid,
  input  logic           q_pop,
  output lirs_pkg::item_t q_item
);
  import lirs_pkg::*;

  item_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              seen;
  logic              push;
  logic              pop;

  assign in_stall = (fill == QCNT_W'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{prime: !seen, frame: in_data};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
      seen   <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
        seen   <= 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* rtl/core/lirs_back.sv */
// lirs_back.sv: phase sequencer, interpolation multipliers and output register
module lirs_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [lirs_pkg::PHASE_W-1:0]  phase_step,
  input  logic [lirs_pkg::CHCNT_W-1:0]  channel_count,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  lirs_pkg::item_t               q_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output lirs_pkg::out_t                out_data
);
  import lirs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t                     state;
  logic [PHASE_W-1:0]         phase;
  logic [CNT_W-1:0]           count;
  logic signed [SAMPLE_W-1:0] prev0, prev1;
  logic signed [SAMPLE_W-1:0] cur0, cur1;

  // multiplier stage
  logic                       m_vld;
  logic signed [49:0]         m_prod0, m_prod1;
  logic signed [SAMPLE_W-1:0] m_prev0, m_prev1;
  logic                       m_stereo;
  logic                       m_last;

  logic                       o_load;
  logic                       m_load;
  logic                       issue;
  logic [PHASE_W:0]           phase_sum;
  logic                       sum_ge_one;
  logic                       run_end;
  logic signed [16:0]         d0, d1;
  logic signed [32:0]         frac;
  logic signed [49:0]         prod0, prod1;
  logic signed [17:0]         s0, s1;
  logic signed [17:0]         r0, r1;

  assign o_load = !out_valid || !out_stall;
  assign m_load = !m_vld || o_load;
  assign issue  = (state == ST_RUN) && m_load;
  assign q_pop  = (state == ST_IDLE) && q_valid;

  assign phase_sum  = {1'b0, phase} + {1'b0, phase_step};
  assign sum_ge_one = (phase_sum >= {1'b0, PHASE_ONE});
  assign run_end    = sum_ge_one || (count == CNT_W'(MAX_UPSAMPLE - 1));

  assign frac  = {1'b0, phase[FRAC_W-1:0]};
  assign d0    = 17'(cur0) - 17'(prev0);
  assign d1    = 17'(cur1) - 17'(prev1);
  assign prod0 = d0 * frac;
  assign prod1 = d1 * frac;

  // floor of the quotient, then step toward zero when negative and inexact
  assign s0 = 18'(m_prev0) + m_prod0[49:32];
  assign s1 = 18'(m_prev1) + m_prod1[49:32];
  assign r0 = (s0[17] && (m_prod0[31:0] != '0)) ? s0 + 18'sd1 : s0;
  assign r1 = (s1[17] && (m_prod1[31:0] != '0)) ? s1 + 18'sd1 : s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= '0;
      count <= '0;
      prev0 <= '0;
      prev1 <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_pop) begin
            if (q_item.prime) begin
              prev0 <= q_item.frame.sample_ch0;
              prev1 <= q_item.frame.sample_ch1;
            end else if (phase[PHASE_W-1:FRAC_W] != '0) begin
              // downsampling skip: no output for this word
              phase <= phase - PHASE_ONE;
              prev0 <= q_item.frame.sample_ch0;
              prev1 <= q_item.frame.sample_ch1;
            end else begin
              count <= '0;
              state <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (issue) begin
            count <= count + 1'b1;
            if (run_end) begin
              phase <= sum_ge_one ? PHASE_W'(phase_sum - {1'b0, PHASE_ONE}) : '0;
              prev0 <= cur0;
              prev1 <= cur1;
              state <= ST_IDLE;
            end else begin
              phase <= phase_sum[PHASE_W-1:0];
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur0 <= q_item.frame.sample_ch0;
      cur1 <= q_item.frame.sample_ch1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else if (m_load) begin
      m_vld <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      m_prod0  <= prod0;
      m_prod1  <= prod1;
      m_prev0  <= prev0;
      m_prev1  <= prev1;
      m_stereo <= (channel_count >= CHCNT_W'(2));
      m_last   <= run_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_load) begin
      out_valid <= m_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load && m_vld) begin
      out_data.out_ch0     <= r0[SAMPLE_W-1:0];
      out_data.out_ch1     <= m_stereo ? r1[SAMPLE_W-1:0] : '0;
      out_data.last_of_run <= m_last;
    end
  end

  a_cap_sets_last: assert property (@(posedge clk) disable iff (rst)
    (issue && count == CNT_W'(MAX_UPSAMPLE - 1)) |=> (m_vld && m_last))
    else $error("run cap reached without last flag");

  a_run_phase_below_one: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (phase[PHASE_W-1:FRAC_W] == '0))
    else $error("phase at or above one during a run");

  a_mult_holds: assert property (@(posedge clk) disable iff (rst)
    (m_vld && !o_load) |=> (m_vld && $stable(m_prod0) && $stable(m_last)))
    else $error("multiplier stage lost a word under stall");

endmodule
